// ===== sv/tcnm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcnm_pkg: shared types and constants for triangle count neighbor match
// Field widths, item kind codes and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tcnm_pkg;

  localparam int KIND_W         = 2;
  localparam int ID_W           = 31;
  localparam int ANCHOR_W       = 6;
  localparam int TOTAL_W        = 32;
  localparam int PAIR_W         = 6;
  localparam int MAX_PAIRS      = 63;
  localparam int DEF_MAX_DEGREE = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_PAIR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic               found;
    logic [TOTAL_W-1:0] match_total;
    logic [ID_W-1:0]    pair_first;
    logic [ID_W-1:0]    pair_second;
    logic               last;
    logic               overflow;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/tcnm_store.sv =====
// ----------------------------------------------------------------------------
// tcnm_store: neighbor id memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcnm_store #(
  parameter int DEPTH = tcnm_pkg::DEF_MAX_DEGREE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic [tcnm_pkg::ID_W-1:0] wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AW-1:0]           raddr_i,
  output logic      [tcnm_pkg::ID_W-1:0] rdata_o
);
  import tcnm_pkg::*;

  logic [ID_W-1:0] mem_q [DEPTH];
  logic [ID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tcnm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcnm_ctrl: sequencer with the shared id comparator
// Loads the store, scans it one entry a cycle for queries, walks pair beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tcnm_ctrl #(
  parameter int MAX_DEGREE = tcnm_pkg::DEF_MAX_DEGREE,
  parameter int AW         = $clog2(MAX_DEGREE),
  parameter int CW         = $clog2(MAX_DEGREE + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tcnm_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [tcnm_pkg::ID_W-1:0]     vertex_id_i,
  input  wire logic                          start_new_i,
  input  wire logic [tcnm_pkg::ANCHOR_W-1:0] anchor_index_i,
  input  wire logic                          slot_free_i,
  output logic                               push_o,
  output tcnm_pkg::res_t                     res_o,
  output logic                               we_o,
  output logic [AW-1:0]                      waddr_o,
  output logic [tcnm_pkg::ID_W-1:0]          wdata_o,
  output logic                               re_o,
  output logic [AW-1:0]                      raddr_o,
  input  wire logic [tcnm_pkg::ID_W-1:0]     rdata_i
);
  import tcnm_pkg::*;

  localparam int EW = (CW > ANCHOR_W + 1) ? CW : ANCHOR_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RESULT = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_PFIRST = 6'b010000,
    ST_PEMIT  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [TOTAL_W-1:0]  hit_q, hit_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [ID_W-1:0]     first_q, first_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [PAIR_W-1:0]   rem_q, rem_d;
  logic                rdv_q;
  logic                found_q, found_d;
  logic                ovf_q, ovf_d;

  logic                accept;
  logic                load_clr;
  logic                match;
  logic                hit_now;
  logic [CW-1:0]       base_count;
  logic [EW-1:0]       pair_span;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign load_clr   = accept && (kind_i == KIND_LOAD) && start_new_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign base_count = start_new_i ? '0 : count_q;
  assign pair_span  = EW'(count_q) - EW'(anchor_index_i) - EW'(1);

  // shared comparator: one stored id against the queried id per cycle
  assign match   = rdv_q && (rdata_i == id_q) &&
                   ((state_q == ST_SCAN) || (state_q == ST_DRAIN));
  assign hit_now = found_q || match;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    hit_d   = hit_q;
    id_d    = id_q;
    first_d = first_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    found_d = found_q;
    ovf_d   = ovf_q;
    we_o    = 1'b0;
    waddr_o = base_count[AW-1:0];
    wdata_o = vertex_id_i;
    re_o    = 1'b0;
    raddr_o = idx_q;
    push_o  = 1'b0;
    res_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_LOAD: begin
              found_d = 1'b0;
              hit_d   = start_new_i ? '0 : hit_q;
              if (base_count < CW'(MAX_DEGREE)) begin
                we_o    = 1'b1;
                count_d = base_count + CW'(1);
                ovf_d   = 1'b0;
              end else begin
                count_d = base_count;
                ovf_d   = 1'b1;
              end
              state_d = ST_RESULT;
            end
            KIND_QUERY: begin
              id_d    = vertex_id_i;
              found_d = 1'b0;
              ovf_d   = 1'b0;
              idx_d   = '0;
              state_d = (count_q == '0) ? ST_RESULT : ST_SCAN;
            end
            KIND_PAIR: begin
              // anchor at or past the last entry: no beats
              if (EW'(anchor_index_i) + EW'(1) < EW'(count_q)) begin
                re_o    = 1'b1;
                raddr_o = AW'(anchor_index_i);
                idx_d   = AW'(anchor_index_i) + AW'(1);
                rem_d   = (pair_span > EW'(MAX_PAIRS)) ? PAIR_W'(MAX_PAIRS)
                                                       : pair_span[PAIR_W-1:0];
                state_d = ST_PFIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        re_o    = 1'b1;
        raddr_o = idx_q;
        found_d = hit_now;
        if (CW'(idx_q) + CW'(1) == count_q) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        found_d = hit_now;
        if (hit_now && (hit_q != '1)) begin
          hit_d = hit_q + TOTAL_W'(1);
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free_i) begin
          push_o            = 1'b1;
          res_o.found       = found_q;
          res_o.match_total = hit_q;
          res_o.last        = 1'b1;
          res_o.overflow    = ovf_q;
          state_d           = ST_IDLE;
        end
      end
      ST_PFIRST: begin
        first_d = rdata_i;
        re_o    = 1'b1;
        raddr_o = idx_q;
        state_d = ST_PEMIT;
      end
      ST_PEMIT: begin
        // hold the read data while the output slot is busy
        if (slot_free_i) begin
          push_o            = 1'b1;
          res_o.match_total = hit_q;
          res_o.pair_first  = first_q;
          res_o.pair_second = rdata_i;
          res_o.last        = (rem_q == PAIR_W'(1));
          if (rem_q == PAIR_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            re_o    = 1'b1;
            raddr_o = idx_q + AW'(1);
            idx_d   = idx_q + AW'(1);
            rem_d   = rem_q - PAIR_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      hit_q   <= '0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      hit_q   <= hit_d;
      rdv_q   <= re_o;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    first_q <= first_d;
    idx_q   <= idx_d;
    rem_q   <= rem_d;
    found_q <= found_d;
    ovf_q   <= ovf_d;
  end

`ifndef NO_ASSERTIONS
  a_drain_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> rdv_q)
    else $error("drain without read data");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_DEGREE))
    else $error("neighbor count past capacity");

  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PEMIT) |-> (rem_q != '0))
    else $error("pair beat with nothing left");

  a_push_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> slot_free_i)
    else $error("result pushed into busy slot");

  a_hit_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_clr |=> (hit_q >= $past(hit_q)))
    else $error("match count fell without a clear");
`endif

endmodule

`default_nettype wire

// ===== sv/triangle_count_neighbor_match_top.sv =====
// ----------------------------------------------------------------------------
// triangle_count_neighbor_match_top: per-vertex neighbor store and matcher
// Loads neighbor ids, answers membership queries, emits neighbor pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per beat: kind
//   load, query or pair. The block works on one item at a time and raises
//   in_stall_o until the item's last result beat sits in the output register.
//   Output channel (out_valid_o / out_stall_i) moves one result per beat from
//   a single output register; stalling it holds the beat, and the sequencer
//   waits for a free slot before the next beat.
//   Sequencing, with N stored neighbors and P pair beats (P up to 63):
//     load  - writes the store below capacity, then gives its result.
//     query - one read port scans the N entries, one entry a cycle, into one
//             shared comparator, then drain and result; empty store: no scan.
//     pair  - P beats, one per cycle from the same read port if not stalled.
//   Pair items with no later entries and items of the unused kind give no
//   beats and leave the block ready on the next cycle.
//   Reset clears the neighbor count, the match count and the output valid;
//   the store itself is not cleared and is only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_count_neighbor_match_top #(
  parameter int MAX_DEGREE = tcnm_pkg::DEF_MAX_DEGREE
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tcnm_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [tcnm_pkg::ID_W-1:0]     vertex_id_i,
  input  wire logic                          start_new_i,
  input  wire logic [tcnm_pkg::ANCHOR_W-1:0] anchor_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               found_o,
  output logic [tcnm_pkg::TOTAL_W-1:0]       match_total_o,
  output logic [tcnm_pkg::ID_W-1:0]          pair_first_o,
  output logic [tcnm_pkg::ID_W-1:0]          pair_second_o,
  output logic                               last_o,
  output logic                               overflow_o
);
  import tcnm_pkg::*;

  localparam int AW = $clog2(MAX_DEGREE);
  localparam int CW = $clog2(MAX_DEGREE + 1);

  logic            slot_free;
  logic            push;
  res_t            res;
  res_t            res_q;
  logic            out_valid_q, out_valid_d;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [ID_W-1:0] wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [ID_W-1:0] rdata;

  // The output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  tcnm_ctrl #(
    .MAX_DEGREE (MAX_DEGREE),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .vertex_id_i    (vertex_id_i),
    .start_new_i    (start_new_i),
    .anchor_index_i (anchor_index_i),
    .slot_free_i    (slot_free),
    .push_o         (push),
    .res_o          (res),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  tcnm_store #(
    .DEPTH (MAX_DEGREE),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Load a new beat on push, drop the old one once taken, else hold.
  assign out_valid_d = push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = res_q.found;
  assign match_total_o = res_q.match_total;
  assign pair_first_o  = res_q.pair_first;
  assign pair_second_o = res_q.pair_second;
  assign last_o        = res_q.last;
  assign overflow_o    = res_q.overflow;

endmodule

`default_nettype wire
